/* rtl/sia_pkg.sv */
package sia_pkg;

  typedef struct packed {
    logic signed [23:0] tab_offset;
    logic [22:0]        tab_span;
    logic [22:0]        label_span;
    logic [22:0]        strip_height;
    logic [15:0]        frame_time;
    logic               geometry_valid;
  } in_t;

  typedef struct packed {
    logic signed [23:0] bar_left;
    logic [22:0]        bar_width;
    logic signed [23:0] bar_top;
    logic               draw_enable;
    logic               unsettled;
  } out_t;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_TGT1 = 14'b00000000000010,
    S_TGT2 = 14'b00000000000100,
    S_ERR  = 14'b00000000001000,
    S_KDT  = 14'b00000000010000,
    S_VEL  = 14'b00000000100000,
    S_IDX  = 14'b00000001000000,
    S_INT  = 14'b00000010000000,
    S_DEC  = 14'b00000100000000,
    S_POS1 = 14'b00001000000000,
    S_POS2 = 14'b00010000000000,
    S_SNAP = 14'b00100000000000,
    S_OUT  = 14'b01000000000000,
    S_MUL  = 14'b10000000000000
  } state_e;

  localparam logic [2:0] REG_STIFF_LEAD  = 3'd0;
  localparam logic [2:0] REG_STIFF_TRAIL = 3'd1;
  localparam logic [2:0] REG_DAMP_LEAD   = 3'd2;
  localparam logic [2:0] REG_DAMP_TRAIL  = 3'd3;
  localparam logic [2:0] REG_PADDING     = 3'd4;
  localparam logic [2:0] REG_THICKNESS   = 3'd5;

  localparam logic [11:0] STIFF_LEAD_RST  = 12'd480;
  localparam logic [11:0] STIFF_TRAIL_RST = 12'd220;
  localparam logic [7:0]  DAMP_LEAD_RST   = 8'd24;
  localparam logic [7:0]  DAMP_TRAIL_RST  = 8'd18;
  localparam logic [15:0] PADDING_RST     = 16'd0;
  localparam logic [15:0] THICKNESS_RST   = 16'd768;

  localparam logic [11:0] DT_DEFAULT = 12'd1092;
  localparam logic [11:0] DT_MAX     = 12'd2185;
  localparam logic [15:0] PAD_MIN    = 16'd2048;
  localparam int          SNAP_LIMIT = 13;
  localparam int          TAYLOR_TERMS = 30;
  localparam int          FRAC_BITS  = 20;

endpackage

/* rtl/spring_indicator_animator_unit.sv */
// Tab indicator spring animator. One input beat per display frame gives one output beat.
// An invalid-geometry frame goes from S_IDLE straight to S_OUT; an unseeded spring (right edge
// at or below zero, as on the first valid frame) passes S_TGT1 and S_TGT2 on to S_OUT.
// A moving frame also steps both edges and S_SNAP; its time is set by the single shared
// bit-serial multiplier (one multiplier bit per cycle, 6 products per edge, left edge then right edge).
// The input side takes a new beat while the previous result waits in the output
// register. Positions are Q.8 pixels, time Q0.16 s; the decay factor comes from an
// interpolated table of DECAY_TABLE_DEPTH+1 entries built at elaboration.
module spring_indicator_animator_unit #(
  parameter int DECAY_TABLE_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sia_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sia_pkg::out_t    out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int IW = $clog2(DECAY_TABLE_DEPTH + 1);
  localparam int SW = sia_pkg::FRAC_BITS + IW;
  localparam logic [63:0] H_STEP = (64'd16 << 30) / DECAY_TABLE_DEPTH;

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [DECAY_TABLE_DEPTH:0][30:0] build_tab();
    logic [DECAY_TABLE_DEPTH:0][30:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int n = 1; n <= sia_pkg::TAYLOR_TERMS; n++) begin
      term = udiv(term * H_STEP, 64'(n) << 30);
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    t[0] = 31'd1 << 30;
    for (int i = 1; i <= DECAY_TABLE_DEPTH; i++) begin
      prod = 64'(t[i-1]) * sum + (64'd1 << 29);
      t[i] = 31'(prod >> 30);
    end
    return t;
  endfunction

  localparam logic [DECAY_TABLE_DEPTH:0][30:0] DECAY_TAB = build_tab();

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic near(input logic signed [63:0] x);
    return (x < 64'(sia_pkg::SNAP_LIMIT)) && (x > -64'(sia_pkg::SNAP_LIMIT));
  endfunction

  // configuration
  logic [11:0] k_lead_q, k_trail_q;
  logic [7:0]  d_lead_q, d_trail_q;
  logic [15:0] pad_q, thick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_lead_q  <= sia_pkg::STIFF_LEAD_RST;
      k_trail_q <= sia_pkg::STIFF_TRAIL_RST;
      d_lead_q  <= sia_pkg::DAMP_LEAD_RST;
      d_trail_q <= sia_pkg::DAMP_TRAIL_RST;
      pad_q     <= sia_pkg::PADDING_RST;
      thick_q   <= sia_pkg::THICKNESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sia_pkg::REG_STIFF_LEAD:  k_lead_q  <= cfg_data_i[11:0];
        sia_pkg::REG_STIFF_TRAIL: k_trail_q <= cfg_data_i[11:0];
        sia_pkg::REG_DAMP_LEAD:   d_lead_q  <= cfg_data_i[7:0];
        sia_pkg::REG_DAMP_TRAIL:  d_trail_q <= cfg_data_i[7:0];
        sia_pkg::REG_PADDING:     pad_q     <= cfg_data_i;
        sia_pkg::REG_THICKNESS:   thick_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sia_pkg::state_e state_q, state_d, ret_q, ret_d;
  sia_pkg::in_t    in_q, in_d;
  sia_pkg::out_t   out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic signed [31:0] pos_q [2];
  logic signed [31:0] pos_d [2];
  logic signed [31:0] vel_q [2];
  logic signed [31:0] vel_d [2];
  logic signed [31:0] tgt_q [2];
  logic signed [31:0] tgt_d [2];
  logic [22:0] tw_q, tw_d;
  logic [11:0] dt_q, dt_d;
  logic        edge_q, edge_d;
  logic        rightward_q, rightward_d;
  logic        zero_q, zero_d;
  logic signed [31:0] v_q, v_d;
  logic [30:0] a_q, a_d, diff_q, diff_d;
  logic [19:0] frac_q, frac_d;
  // bit-serial multiplier
  logic [63:0] mcand_q, mcand_d, acc_q, acc_d;
  logic [31:0] mplier_q, mplier_d;
  logic [4:0]  cnt_q, cnt_d;

  logic               mul_go;
  logic [63:0]        mul_a;
  logic [31:0]        mul_b;
  logic [4:0]         mul_n;
  sia_pkg::state_e    mul_ret;

  logic        lead;
  logic [11:0] k_sel;
  logic [7:0]  d_sel;
  logic [17:0] pad3;
  logic [15:0] padm;
  logic [24:0] tw0;
  logic [22:0] twm;
  logic signed [24:0] diff25;
  logic signed [31:0] tl, tr;
  logic signed [32:0] err;
  logic signed [31:0] nvel;
  logic [SW-1:0] scaled;
  logic [IW-1:0] idx;
  logic [30:0]   fdec;
  logic signed [32:0] wdt;
  logic signed [31:0] lsat;

  assign in_ready_o  = (state_q == sia_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    in_d = in_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pos_d = pos_q;
    vel_d = vel_q;
    tgt_d = tgt_q;
    tw_d = tw_q;
    dt_d = dt_q;
    edge_d = edge_q;
    rightward_d = rightward_q;
    zero_d = zero_q;
    v_d = v_q;
    a_d = a_q;
    diff_d = diff_q;
    frac_d = frac_q;
    mcand_d = mcand_q;
    acc_d = acc_q;
    mplier_d = mplier_q;
    cnt_d = cnt_q;
    mul_go = 1'b0;
    mul_a = '0;
    mul_b = '0;
    mul_n = '0;
    mul_ret = sia_pkg::S_IDLE;

    lead  = rightward_q ^ edge_q;
    k_sel = lead ? k_lead_q : k_trail_q;
    d_sel = lead ? d_lead_q : d_trail_q;
    pad3  = {2'b0, pad_q} + {1'b0, pad_q, 1'b0};
    padm  = (pad3[17:2] < sia_pkg::PAD_MIN) ? sia_pkg::PAD_MIN : pad3[17:2];
    tw0   = {2'b0, in_q.label_span} + {8'b0, padm, 1'b0};
    twm   = (tw0 < {2'b0, in_q.tab_span}) ? tw0[22:0] : in_q.tab_span;
    diff25 = $signed({2'b0, in_q.tab_span}) - $signed({2'b0, tw_q});
    tl = {{8{in_q.tab_offset[23]}}, in_q.tab_offset} + {{8{diff25[24]}}, diff25[24:1]};
    tr = tl + {9'b0, tw_q};
    err = {tgt_q[edge_q][31], tgt_q[edge_q]} - {pos_q[edge_q][31], pos_q[edge_q]};
    nvel = sat32(rnd_shift($signed(acc_q), 30));
    scaled = SW'(acc_q[19:0]) * SW'(DECAY_TABLE_DEPTH);
    idx = scaled[SW-1:sia_pkg::FRAC_BITS];
    fdec = a_q - acc_q[50:20];
    wdt = {pos_q[1][31], pos_q[1]} - {pos_q[0][31], pos_q[0]};
    lsat = pos_q[0];
    if (pos_q[0] > 32'sd8388607) lsat = 32'sd8388607;
    if (pos_q[0] < -32'sd8388608) lsat = -32'sd8388608;

    unique case (state_q)
      sia_pkg::S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          zero_d = !in_data_i.geometry_valid;
          state_d = in_data_i.geometry_valid ? sia_pkg::S_TGT1 : sia_pkg::S_OUT;
        end
      end
      sia_pkg::S_TGT1: begin
        tw_d = (twm < {7'b0, thick_q}) ? {7'b0, thick_q} : twm;
        state_d = sia_pkg::S_TGT2;
      end
      sia_pkg::S_TGT2: begin
        tgt_d[0] = tl;
        tgt_d[1] = tr;
        if (in_q.frame_time == 16'd0) dt_d = sia_pkg::DT_DEFAULT;
        else if (in_q.frame_time > 16'(sia_pkg::DT_MAX)) dt_d = sia_pkg::DT_MAX;
        else dt_d = in_q.frame_time[11:0];
        rightward_d = (tl >= pos_q[0]);
        edge_d = 1'b0;
        if (pos_q[1] <= 32'sd0) begin
          pos_d[0] = tl;
          pos_d[1] = tr;
          vel_d[0] = '0;
          vel_d[1] = '0;
          state_d = sia_pkg::S_OUT;
        end else begin
          state_d = sia_pkg::S_ERR;
        end
      end
      sia_pkg::S_ERR: begin
        mul_go = 1'b1;
        mul_a = {{31{err[32]}}, err};
        mul_b = {20'b0, k_sel};
        mul_n = 5'd12;
        mul_ret = sia_pkg::S_KDT;
      end
      sia_pkg::S_KDT: begin
        mul_go = 1'b1;
        mul_a = acc_q;
        mul_b = {20'b0, dt_q};
        mul_n = 5'd12;
        mul_ret = sia_pkg::S_VEL;
      end
      sia_pkg::S_VEL: begin
        v_d = sat32(64'(vel_q[edge_q]) + rnd_shift($signed(acc_q), 16));
        mul_go = 1'b1;
        mul_a = {52'b0, dt_q};
        mul_b = {24'b0, d_sel};
        mul_n = 5'd8;
        mul_ret = sia_pkg::S_IDX;
      end
      sia_pkg::S_IDX: begin
        frac_d = scaled[sia_pkg::FRAC_BITS-1:0];
        if (32'(idx) >= 32'(DECAY_TABLE_DEPTH)) begin
          a_d = DECAY_TAB[DECAY_TABLE_DEPTH];
          diff_d = '0;
        end else begin
          a_d = DECAY_TAB[idx];
          diff_d = DECAY_TAB[idx] - DECAY_TAB[idx + IW'(1)];
        end
        state_d = sia_pkg::S_INT;
      end
      sia_pkg::S_INT: begin
        mul_go = 1'b1;
        mul_a = {33'b0, diff_q};
        mul_b = {12'b0, frac_q};
        mul_n = 5'd20;
        mul_ret = sia_pkg::S_DEC;
      end
      sia_pkg::S_DEC: begin
        mul_go = 1'b1;
        mul_a = 64'(v_q);
        mul_b = {1'b0, fdec};
        mul_n = 5'd31;
        mul_ret = sia_pkg::S_POS1;
      end
      sia_pkg::S_POS1: begin
        vel_d[edge_q] = nvel;
        mul_go = 1'b1;
        mul_a = 64'(nvel);
        mul_b = {20'b0, dt_q};
        mul_n = 5'd12;
        mul_ret = sia_pkg::S_POS2;
      end
      sia_pkg::S_POS2: begin
        pos_d[edge_q] = sat32(64'(pos_q[edge_q]) + rnd_shift($signed(acc_q), 16));
        edge_d = 1'b1;
        state_d = edge_q ? sia_pkg::S_SNAP : sia_pkg::S_ERR;
      end
      sia_pkg::S_SNAP: begin
        if (near(64'(pos_q[0]) - 64'(tgt_q[0])) && near(64'(pos_q[1]) - 64'(tgt_q[1])) &&
            near(64'(vel_q[0])) && near(64'(vel_q[1]))) begin
          pos_d = tgt_q;
          vel_d[0] = '0;
          vel_d[1] = '0;
        end
        state_d = sia_pkg::S_OUT;
      end
      sia_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (zero_q) begin
            out_d = '0;
          end else begin
            out_d.bar_left = lsat[23:0];
            if (wdt < $signed({17'b0, thick_q})) out_d.bar_width = {7'b0, thick_q};
            else if (wdt > 33'sd8388607) out_d.bar_width = 23'h7fffff;
            else out_d.bar_width = wdt[22:0];
            out_d.bar_top = {1'b0, in_q.strip_height} - {8'b0, thick_q};
            out_d.draw_enable = (in_q.strip_height != 23'd0);
            out_d.unsettled = (pos_q[0] != tgt_q[0]) || (pos_q[1] != tgt_q[1]);
          end
          state_d = sia_pkg::S_IDLE;
        end
      end
      sia_pkg::S_MUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) state_d = ret_q;
      end
      default: state_d = sia_pkg::S_IDLE;
    endcase

    if (mul_go) begin
      acc_d = '0;
      mcand_d = mul_a;
      mplier_d = mul_b;
      cnt_d = mul_n;
      ret_d = mul_ret;
      state_d = sia_pkg::S_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sia_pkg::S_IDLE;
      ret_q <= sia_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      vel_q[0] <= '0;
      vel_q[1] <= '0;
      cnt_q <= '0;
      edge_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      out_valid_q <= out_valid_d;
      pos_q <= pos_d;
      vel_q <= vel_d;
      cnt_q <= cnt_d;
      edge_q <= edge_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    out_q <= out_d;
    tgt_q <= tgt_d;
    tw_q <= tw_d;
    dt_q <= dt_d;
    rightward_q <= rightward_d;
    v_q <= v_d;
    a_q <= a_d;
    diff_q <= diff_d;
    frac_q <= frac_d;
    mcand_q <= mcand_d;
    acc_q <= acc_d;
    mplier_q <= mplier_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sia_pkg::S_MUL) |-> (cnt_q != 5'd0))
    else $error("multiplier running with zero count");

  a_invalid_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_data_i.geometry_valid) |=> (state_q == sia_pkg::S_OUT))
    else $error("invalid frame did not go straight to output");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i) |=> ($stable(pos_q[0]) && $stable(pos_q[1])))
    else $error("spring state moved while idle");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int TABLE_DEPTH = 64;
  localparam int ARG_SHIFT = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sia_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sia_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = sia_pkg::REG_STIFF_LEAD;
  logic [15:0] cfg_data_i = '0;

  spring_indicator_animator_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and configuration
  longint decay_lut[TABLE_DEPTH + 1];
  longint k_lead, k_trail, d_lead, d_trail, pad_reg, thick_reg;
  longint lpos, rpos, lvel, rvel;

  sia_pkg::in_t  frame_q[$];
  sia_pkg::out_t span_q[$];
  int   errors = 0;
  int   mismatches = 0;
  int   hold_off = 0;
  bit   hold_req = 1'b0;
  bit   hold_seen = 1'b0;

  function automatic longint fshift(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint rshift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void build_lut();
    longint unsigned h, term, stp;
    longint acc;
    h = (64'd16 << 30) / TABLE_DEPTH;
    term = 64'd1 << 30;
    acc = 64'sd1 <<< 30;
    for (int n = 1; n <= 30; n++) begin
      term = (term * h) / (longint'(n) << 30);
      if (n & 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    stp = acc;
    decay_lut[0] = 64'd1 << 30;
    for (int i = 1; i <= TABLE_DEPTH; i++)
      decay_lut[i] = ((decay_lut[i - 1] * stp) + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint decay_of(longint damp, longint dt);
    longint unsigned scaled, idx, frac, a, b;
    scaled = damp * dt * TABLE_DEPTH;
    idx = scaled >> ARG_SHIFT;
    frac = scaled & ((64'd1 << ARG_SHIFT) - 1);
    if (idx >= TABLE_DEPTH) return decay_lut[TABLE_DEPTH];
    a = decay_lut[idx];
    b = decay_lut[idx + 1];
    return (a - (((a - b) * frac) >> ARG_SHIFT)) & 64'hFFFF_FFFF;
  endfunction

  task automatic spring_edge(inout longint pos, inout longint vel, input longint tgt,
                             input longint k, input longint damp, input longint dt);
    longint v;
    v = sat32(vel + rshift((tgt - pos) * k * dt, 16));
    v = rshift(v * decay_of(damp, dt), 30);
    vel = sat32(v);
    pos = sat32(pos + rshift(vel * dt, 16));
  endtask

  function automatic longint absv(longint x);
    return x < 0 ? -x : x;
  endfunction

  task automatic predict_frame(input sia_pkg::in_t f, output sia_pkg::out_t r);
    longint off, pad, tw, tl, tr, dt, wid, lo;
    bit fwd;
    r = '0;
    if (!f.geometry_valid) return;
    off = longint'(f.tab_offset);
    pad = (3 * pad_reg) >> 2;
    if (pad < sia_pkg::PAD_MIN) pad = sia_pkg::PAD_MIN;
    tw = longint'(f.label_span) + 2 * pad;
    if (longint'(f.tab_span) < tw) tw = f.tab_span;
    if (tw < thick_reg) tw = thick_reg;
    tl = 64'(signed'(32'(off + fshift(longint'(f.tab_span) - tw, 1))));
    tr = 64'(signed'(32'(off + fshift(longint'(f.tab_span) - tw, 1) + tw)));
    if (rpos <= 0) begin
      lpos = tl; rpos = tr; lvel = 0; rvel = 0;
    end else begin
      fwd = tl >= lpos;
      dt = f.frame_time;
      if (dt == 0) dt = sia_pkg::DT_DEFAULT;
      if (dt > sia_pkg::DT_MAX) dt = sia_pkg::DT_MAX;
      spring_edge(lpos, lvel, tl, fwd ? k_lead : k_trail, fwd ? d_lead : d_trail, dt);
      spring_edge(rpos, rvel, tr, fwd ? k_trail : k_lead, fwd ? d_trail : d_lead, dt);
      if (absv(lpos - tl) < sia_pkg::SNAP_LIMIT && absv(rpos - tr) < sia_pkg::SNAP_LIMIT &&
          absv(lvel) < sia_pkg::SNAP_LIMIT && absv(rvel) < sia_pkg::SNAP_LIMIT) begin
        lpos = tl; rpos = tr; lvel = 0; rvel = 0;
      end
    end
    lo = lpos;
    if (lo > 8388607) lo = 8388607;
    if (lo < -8388608) lo = -8388608;
    wid = rpos - lpos;
    if (wid < thick_reg) wid = thick_reg;
    if (wid > 8388607) wid = 8388607;
    r.bar_left = lo[23:0];
    r.bar_width = wid[22:0];
    r.bar_top = 24'(longint'(f.strip_height) - thick_reg);
    r.draw_enable = f.strip_height != 0;
    r.unsettled = (lpos != tl) || (rpos != tr);
  endtask

  // driver: bursts with gaps; the front of frame_q is the beat on the bus
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    sia_pkg::out_t r;
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) begin
          predict_frame(in_data_i, r);
          span_q.push_back(r);
          void'(frame_q.pop_front());
        end
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (frame_q.size() > 0) begin
          in_data_i <= frame_q[0];
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else burst_left <= burst_left - 1;
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off when requested
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_off <= 3000;
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sia_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (span_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected beat %p", out_data_o);
      end else begin
        e = span_q.pop_front();
        if (e.bar_left !== out_data_o.bar_left || e.bar_width !== out_data_o.bar_width ||
            e.bar_top !== out_data_o.bar_top || e.draw_enable !== out_data_o.draw_enable ||
            e.unsettled !== out_data_o.unsettled) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch exp %p got %p", e, out_data_o);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sia_pkg::REG_STIFF_LEAD:  k_lead = val[11:0];
      sia_pkg::REG_STIFF_TRAIL: k_trail = val[11:0];
      sia_pkg::REG_DAMP_LEAD:   d_lead = val[7:0];
      sia_pkg::REG_DAMP_TRAIL:  d_trail = val[7:0];
      sia_pkg::REG_PADDING:     pad_reg = val;
      default:                  thick_reg = val;
    endcase
  endtask

  task automatic drain();
    while (frame_q.size() != 0 || in_valid_i || span_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic sia_pkg::in_t rand_frame(int target, int spread);
    sia_pkg::in_t f;
    f.tab_offset = 24'(target + $urandom_range(0, 2 * spread) - spread);
    f.tab_span = $urandom_range(0, 3) == 0 ? 23'($urandom) : 23'($urandom_range(2000, 60000));
    f.label_span = $urandom_range(0, 3) == 0 ? 23'($urandom) : 23'($urandom_range(0, 40000));
    f.strip_height = $urandom_range(0, 7) == 0 ? 23'd0 : 23'($urandom);
    f.frame_time = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2200));
    f.geometry_valid = $urandom_range(0, 9) != 0;
    return f;
  endfunction

  task automatic push_frame(input logic signed [23:0] off, input logic [22:0] span,
                            input logic [22:0] lbl, input logic [22:0] sh,
                            input logic [15:0] ft, input logic gv);
    sia_pkg::in_t f;
    f.tab_offset = off; f.tab_span = span; f.label_span = lbl;
    f.strip_height = sh; f.frame_time = ft; f.geometry_valid = gv;
    frame_q.push_back(f);
  endtask

  initial begin
    int anchor;
    k_lead = sia_pkg::STIFF_LEAD_RST; k_trail = sia_pkg::STIFF_TRAIL_RST;
    d_lead = sia_pkg::DAMP_LEAD_RST; d_trail = sia_pkg::DAMP_TRAIL_RST;
    pad_reg = sia_pkg::PADDING_RST; thick_reg = sia_pkg::THICKNESS_RST;
    lpos = 0; rpos = 0; lvel = 0; rvel = 0;
    build_lut();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: invalid, seeding, zero strip, dt default/clamp, leftward, extremes
    push_frame(24'sd1000, 23'd5000, 23'd3000, 23'd4000, 16'd0, 1'b0);
    push_frame(24'sd0, 23'd20000, 23'd8000, 23'd2000, 16'd1092, 1'b1);
    push_frame(24'sd30000, 23'd20000, 23'd8000, 23'd0, 16'd0, 1'b1);
    push_frame(24'sd30000, 23'd20000, 23'd8000, 23'd2000, 16'hFFFF, 1'b1);
    push_frame(-24'sd5000, 23'd9000, 23'd1000, 23'd2000, 16'd2185, 1'b1);
    for (int i = 0; i < 8; i++) push_frame(-24'sd5000, 23'd9000, 23'd1000, 23'd500, 16'd2185, 1'b1);
    push_frame(24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'd1, 1'b1);
    push_frame(24'sh800000, 23'h7FFFFF, 23'd0, 23'h7FFFFF, 16'd2186, 1'b1);
    push_frame(24'sd0, 23'd0, 23'd0, 23'd1, 16'd1000, 1'b1);
    push_frame(24'sh800000, 23'd0, 23'h7FFFFF, 23'd0, 16'hFFFF, 1'b0);
    drain();

    anchor = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(sia_pkg::REG_STIFF_LEAD, 16'hFFF);
          write_reg(sia_pkg::REG_STIFF_TRAIL, 16'hFFF);
          write_reg(sia_pkg::REG_DAMP_LEAD, 16'hFF);
          write_reg(sia_pkg::REG_DAMP_TRAIL, 16'hFF);
          write_reg(sia_pkg::REG_PADDING, 16'hFFFF);
          write_reg(sia_pkg::REG_THICKNESS, 16'hFFFF);
        end
        1: begin
          write_reg(sia_pkg::REG_STIFF_LEAD, 16'd0);
          write_reg(sia_pkg::REG_STIFF_TRAIL, 16'd0);
          write_reg(sia_pkg::REG_DAMP_LEAD, 16'd0);
          write_reg(sia_pkg::REG_DAMP_TRAIL, 16'd0);
          write_reg(sia_pkg::REG_PADDING, 16'd0);
          write_reg(sia_pkg::REG_THICKNESS, 16'd0);
        end
        2: begin
          write_reg(sia_pkg::REG_STIFF_LEAD, 16'd480);
          write_reg(sia_pkg::REG_STIFF_TRAIL, 16'd220);
          write_reg(sia_pkg::REG_DAMP_LEAD, 16'd24);
          write_reg(sia_pkg::REG_DAMP_TRAIL, 16'd18);
          write_reg(sia_pkg::REG_PADDING, 16'd4000);
          write_reg(sia_pkg::REG_THICKNESS, 16'd768);
        end
        default: begin
          write_reg(sia_pkg::REG_STIFF_LEAD, 16'($urandom));
          write_reg(sia_pkg::REG_STIFF_TRAIL, 16'($urandom));
          write_reg(sia_pkg::REG_DAMP_LEAD, 16'($urandom));
          write_reg(sia_pkg::REG_DAMP_TRAIL, 16'($urandom));
          write_reg(sia_pkg::REG_PADDING, 16'($urandom_range(0, 20000)));
          write_reg(sia_pkg::REG_THICKNESS, 16'($urandom_range(0, 3000)));
        end
      endcase
      for (int i = 0; i < 72; i++) begin
        if (i % 12 == 0) anchor = $urandom_range(0, 1) ? $urandom_range(0, 400000) : $urandom;
        frame_q.push_back(rand_frame(anchor, i % 12 < 9 ? 0 : 5000));
      end
      if (ph == 2) hold_req = 1'b1;
      drain();
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

endmodule
